// File: rtl/lsra_pkg.sv
`default_nettype none

package lsra_pkg;

    // sizing
    localparam int MAX_REGS = 8;
    localparam int REG_W    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int COUNT_W  = $clog2(MAX_REGS + 1);
    localparam int VREG_W   = 16;
    localparam int PT_W     = 16;
    localparam int LOC_W    = 16;
    localparam int CFG_W    = 4;

    // config port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_IDX_COUNT = '0;
    localparam logic [CFG_W-1:0] REG_COUNT_RESET = CFG_W'(3);

    // result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_INSERT = 2'd2,
        OP_SPILL  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [VREG_W-1:0] vreg;
        logic [PT_W-1:0]   end_pt;
        logic [REG_W-1:0]  phys;
    } lsra_entry_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [PT_W-1:0]   start;
        lsra_entry_t       new_entry;
    } lsra_ctrl_t;

    // compare results a cell shows its neighbors
    typedef struct packed {
        logic keep;   // active and survives expiry
        logic ge;     // active and end <= new end: moves toward the tail on insert
        logic gt;     // active and end > new end
    } lsra_flags_t;

    typedef struct packed {
        logic [VREG_W-1:0] assigned_vreg;
        logic              on_stack;
        logic [LOC_W-1:0]  location;
        logic              last_result;
    } lsra_result_t;

    // register count as used: 0 acts as 1, above MAX_REGS clamps
    function automatic logic [COUNT_W-1:0] lsra_eff_count(input logic [CFG_W-1:0] v);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(v);
        if (v == '0)
        begin
            n = COUNT_W'(1);
        end
        else if (32'(v) > MAX_REGS)
        begin
            n = COUNT_W'(MAX_REGS);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lsra_interval_if.sv
`default_nettype none

interface lsra_interval_if import lsra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VREG_W-1:0] interval_vreg;
    logic [PT_W-1:0]   interval_start;
    logic [PT_W-1:0]   interval_end;
    logic              first_of_function;

    modport source (
        output valid, interval_vreg, interval_start, interval_end, first_of_function,
        input  ready
    );
    modport sink (
        input  valid, interval_vreg, interval_start, interval_end, first_of_function,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/lsra_result_if.sv
`default_nettype none

interface lsra_result_if import lsra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VREG_W-1:0] assigned_vreg;
    logic              on_stack;
    logic [LOC_W-1:0]  location;
    logic              last_result;

    modport source (
        output valid, assigned_vreg, on_stack, location, last_result,
        input  ready
    );
    modport sink (
        input  valid, assigned_vreg, on_stack, location, last_result,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/lsra_cell.sv
`default_nettype none

// One slot of the allocation row. Below the active count it holds a live
// interval; at or above it, it holds one free register of the stack.
module lsra_cell import lsra_pkg::*; (
    input  logic             clk,
    input  lsra_ctrl_t       ctrl,
    input  logic             active,
    input  logic             first_free,
    input  logic [REG_W-1:0] init_phys,
    input  lsra_entry_t      left_entry,
    input  lsra_flags_t      left_flags,
    input  lsra_entry_t      right_entry,
    input  lsra_flags_t      right_flags,
    output lsra_entry_t      entry,
    output lsra_flags_t      flags
);

    lsra_entry_t entry_reg;
    lsra_entry_t entry_next;

    always_comb
    begin
        flags.keep = active && (entry_reg.end_pt >= ctrl.start);
        flags.ge   = active && (entry_reg.end_pt <= ctrl.new_entry.end_pt);
        flags.gt   = active && (entry_reg.end_pt >  ctrl.new_entry.end_pt);
    end

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_CLEAR:
            begin
                entry_next.phys = init_phys;
            end
            OP_INSERT:
            begin
                // shift toward the tail, new word lands where the left stops shifting
                if (flags.ge || first_free)
                begin
                    entry_next = left_flags.ge ? left_entry : ctrl.new_entry;
                end
            end
            OP_SPILL:
            begin
                // head leaves; later-ending words move up, new word after them
                if (right_flags.gt)
                begin
                    entry_next = right_entry;
                end
                else if (flags.gt)
                begin
                    entry_next = ctrl.new_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: rtl/lsra_apb_regs.sv
`default_nettype none

module lsra_apb_regs import lsra_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] eff_count,
    output logic               cfg_clear
);

    logic [CFG_W-1:0]   count_reg;
    logic [COUNT_W-1:0] eff_reg;
    logic               hit;
    logic               wr_en;

    assign pready = 1'b1;
    assign hit    = (paddr[ADDR_W-1:2] == REG_IDX_COUNT);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= REG_COUNT_RESET;
            eff_reg   <= lsra_eff_count(REG_COUNT_RESET);
        end
        else if (wr_en)
        begin
            count_reg <= pwdata[CFG_W-1:0];
            eff_reg   <= lsra_eff_count(pwdata[CFG_W-1:0]);
        end
    end

    assign prdata    = hit ? DATA_W'(count_reg) : '0;
    assign eff_count = eff_reg;
    assign cfg_clear = wr_en;

endmodule

`default_nettype wire

// File: rtl/lsra_out_queue.sv
`default_nettype none

// Two-word result buffer; up to two words enter per cycle.
module lsra_out_queue import lsra_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push0,
    input  logic              push1,
    input  lsra_result_t      data0,
    input  lsra_result_t      data1,
    output logic [QCNT_W-1:0] free_slots,
    lsra_result_if.source     result
);

    lsra_result_t      q_reg  [QUEUE_DEPTH];
    lsra_result_t      q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              pop;

    assign pop = result.valid && result.ready;

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - QCNT_W'(1);
        end
        if (push0)
        begin
            if (cnt_next == '0)
            begin
                q_next[0] = data0;
                q_next[1] = data1;
            end
            else
            begin
                q_next[1] = data0;
            end
            cnt_next = cnt_next + QCNT_W'(1) + QCNT_W'(push1);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign free_slots           = QCNT_W'(QUEUE_DEPTH) - cnt_reg;
    assign result.valid         = (cnt_reg != '0);
    assign result.assigned_vreg = q_reg[0].assigned_vreg;
    assign result.on_stack      = q_reg[0].on_stack;
    assign result.location      = q_reg[0].location;
    assign result.last_result   = q_reg[0].last_result;

endmodule

`default_nettype wire

// File: rtl/linear_scan_register_allocator.sv
// Linear scan register allocator.
// Input channel (interval): one word per live interval, in order of rising
// start: vreg, start, end, and first_of_function, which resets the pools,
// the active set and the stack slot counter before that interval.
// Output channel (result): one word per interval, or two when the active
// interval with the latest end is spilled: first the new interval in the
// register it frees (last_result 0), then the spilled one on its stack slot.
// APB port: register_count at byte address 0 (1..8 used, 0 acts as 1); a
// write reloads the free pool and empties the active set.
// Steps: accept, expiry cycle, insert/spill cycle; a new word is taken in the
// insert/spill cycle, so the block takes a new interval while it commits the last.
// An interval with two result words right after another such interval
// waits for buffer room in the insert/spill cycle, even with a ready receiver.
// The first result reaches the port from the result buffer after insert/spill.
// The two-word result buffer must have room for all results of an interval
// before the insert/spill cycle commits; while the receiver stalls, the
// block holds in that cycle and stops taking input.
// Reset: register_count 3, empty active set, slot counter 0. The cell row
// is loaded with the free registers during the first expiry cycle after
// reset or after a config write.
`default_nettype none

module linear_scan_register_allocator import lsra_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    lsra_interval_if.sink     interval,
    lsra_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXPIRE = 3'b010,
        ST_ALLOC  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] ac_reg, ac_next;         // active intervals, cells [0..ac)
    logic [LOC_W-1:0]   slot_reg, slot_next;     // next stack slot, saturating
    logic               clear_pend_reg, clear_pend_next;

    // latched interval word
    logic [VREG_W-1:0]  in_vreg_reg;
    logic [PT_W-1:0]    in_start_reg;
    logic [PT_W-1:0]    in_end_reg;
    logic               in_first_reg;

    logic [COUNT_W-1:0] n_eff;
    logic               cfg_clear;
    logic               in_ready;
    logic               in_accept;

    lsra_ctrl_t         ctrl;
    lsra_entry_t        cell_entry [MAX_REGS];
    lsra_flags_t        cell_flags [MAX_REGS];
    logic [COUNT_W-1:0] keep_count;

    logic               do_alloc;
    logic               do_swap;
    logic [REG_W-1:0]   pop_phys;
    logic [LOC_W-1:0]   slot_inc;
    logic [QCNT_W-1:0]  free_slots;
    logic               room_ok;
    logic               commit;
    logic               slot_clear;
    logic               push0, push1;
    lsra_result_t       res0, res1;

    //--------------------------------------------------------------------
    // config
    //--------------------------------------------------------------------
    lsra_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_count (n_eff),
        .cfg_clear (cfg_clear)
    );

    //--------------------------------------------------------------------
    // cell row: active intervals sorted by falling end from cell 0, then
    // the free stack with its top at cell ac. Cell c loads n-1-c on clear.
    //--------------------------------------------------------------------
    for (genvar i = 0; i < MAX_REGS; i++)
    begin : g_cell
        lsra_entry_t      l_entry, r_entry;
        lsra_flags_t      l_flags, r_flags;
        logic [REG_W-1:0] init_phys;

        if (i == 0)
        begin : g_head
            assign l_entry = '0;
            assign l_flags = '0;
        end
        else
        begin : g_mid_l
            assign l_entry = cell_entry[i-1];
            assign l_flags = cell_flags[i-1];
        end

        if (i == MAX_REGS - 1)
        begin : g_tail
            assign r_entry = '0;
            assign r_flags = '0;
        end
        else
        begin : g_mid_r
            assign r_entry = cell_entry[i+1];
            assign r_flags = cell_flags[i+1];
        end

        assign init_phys = REG_W'(n_eff - COUNT_W'(i + 1));

        lsra_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .active      (COUNT_W'(i) < ac_reg),
            .first_free  (COUNT_W'(i) == ac_reg),
            .init_phys   (init_phys),
            .left_entry  (l_entry),
            .left_flags  (l_flags),
            .right_entry (r_entry),
            .right_flags (r_flags),
            .entry       (cell_entry[i]),
            .flags       (cell_flags[i])
        );
    end

    // survivors of expiry form a prefix of the row
    always_comb
    begin
        keep_count = '0;
        for (int i = 0; i < MAX_REGS; i++)
        begin
            keep_count = keep_count + COUNT_W'(cell_flags[i].keep);
        end
    end

    //--------------------------------------------------------------------
    // insert / spill decision
    //--------------------------------------------------------------------
    assign do_alloc = (ac_reg < n_eff);
    // row full: head holds the latest end
    assign do_swap  = !do_alloc && cell_flags[0].gt;
    assign pop_phys = cell_entry[ac_reg[REG_W-1:0]].phys;
    assign slot_inc = (slot_reg == '1) ? slot_reg : slot_reg + LOC_W'(1);
    assign room_ok  = (free_slots >= (do_swap ? QCNT_W'(2) : QCNT_W'(1)));
    assign commit   = (state_reg == ST_ALLOC) && room_ok;

    always_comb
    begin
        ctrl.start            = in_start_reg;
        ctrl.new_entry.vreg   = in_vreg_reg;
        ctrl.new_entry.end_pt = in_end_reg;
        ctrl.new_entry.phys   = do_alloc ? pop_phys : cell_entry[0].phys;
        ctrl.op               = OP_HOLD;

        res0.assigned_vreg = in_vreg_reg;
        res0.on_stack      = !do_alloc && !do_swap;
        res0.location      = (do_alloc || do_swap) ? LOC_W'(ctrl.new_entry.phys) : slot_reg;
        res0.last_result   = !do_swap;

        res1.assigned_vreg = cell_entry[0].vreg;
        res1.on_stack      = 1'b1;
        res1.location      = slot_reg;
        res1.last_result   = 1'b1;

        state_next      = state_reg;
        ac_next         = ac_reg;
        slot_next       = slot_reg;
        clear_pend_next = clear_pend_reg;
        in_ready        = 1'b0;
        push0           = 1'b0;
        push1           = 1'b0;
        slot_clear      = cfg_clear;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (interval.valid)
                begin
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                if (clear_pend_reg || in_first_reg)
                begin
                    ctrl.op         = OP_CLEAR;
                    ac_next         = '0;
                    slot_next       = '0;
                    clear_pend_next = 1'b0;
                    slot_clear      = 1'b1;
                end
                else
                begin
                    ac_next = keep_count;
                end
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                if (room_ok)
                begin
                    push0    = 1'b1;
                    push1    = do_swap;
                    in_ready = 1'b1;
                    if (do_alloc)
                    begin
                        ctrl.op = OP_INSERT;
                        ac_next = ac_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        ctrl.op   = do_swap ? OP_SPILL : OP_HOLD;
                        slot_next = slot_inc;
                    end
                    state_next = interval.valid ? ST_EXPIRE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // config write: empty the set now, reload the row at next expiry
        if (cfg_clear)
        begin
            ac_next         = '0;
            slot_next       = '0;
            clear_pend_next = 1'b1;
        end
    end

    assign interval.ready = in_ready;
    assign in_accept      = interval.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ac_reg         <= '0;
            slot_reg       <= '0;
            clear_pend_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            ac_reg         <= ac_next;
            slot_reg       <= slot_next;
            clear_pend_reg <= clear_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_vreg_reg  <= interval.interval_vreg;
            in_start_reg <= interval.interval_start;
            in_end_reg   <= interval.interval_end;
            in_first_reg <= interval.first_of_function;
        end
    end

    //--------------------------------------------------------------------
    // result buffer
    //--------------------------------------------------------------------
    lsra_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (push0),
        .push1      (push1),
        .data0      (res0),
        .data1      (res1),
        .free_slots (free_slots),
        .result     (result)
    );

    //--------------------------------------------------------------------
    // checks
    //--------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ac_reg <= n_eff)
        else $error("active count above register count");

    a_swap_full: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && do_swap) |-> (ac_reg == n_eff))
        else $error("register handed over while free registers remain");

    a_slot_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !slot_clear |=> (slot_reg >= $past(slot_reg)))
        else $error("stack slot counter went backward");

endmodule

`default_nettype wire
